// ----- rtl/esht_pkg.sv -----
package esht_pkg;

    // Channel and field geometry
    localparam int NumCh     = 5;
    localparam int HalfW     = 16;
    localparam int TotalW    = 48;
    localparam int IncW      = 34;
    localparam int MaskW     = 30;
    localparam int CountW    = 5;
    localparam int CfgW      = 5;
    localparam int ClockBit  = 14;
    localparam int HighHitW  = 14;

    // Stream payload widths
    localparam int InDataW   = 2 * HalfW + 2 * HalfW * NumCh;
    localparam int OutUsedW  = MaskW + CountW + 1 + TotalW * NumCh;
    localparam int OutDataW  = ((OutUsedW + 7) / 8) * 8;
    localparam int OutTotOfs = MaskW + CountW + 1;

    // Register reset value: alternate clear rule on channel 4 only
    localparam logic [CfgW-1:0] ClearRuleReset = CfgW'(16);

    // Saturation bounds of a running total
    localparam logic [TotalW-1:0] TotalMax = {1'b0, {(TotalW-1){1'b1}}};
    localparam logic [TotalW-1:0] TotalMin = {1'b1, {(TotalW-1){1'b0}}};

    typedef logic [HalfW-1:0]  t_half;
    typedef logic [TotalW-1:0] t_total;

    // Per-lane pipeline controls
    typedef struct packed {
        logic load;   // capture the item's increment, store its scaler words
        logic acc;    // add the held increment into the running total
    } t_lane_ctl;

endpackage

// ----- rtl/event_scaler_and_hit_tracker_core.sv -----
// Event scaler and hit tracker. Each input item is one detector event: two
// coincidence registers and five scaler channels split in 16-bit halves. Each
// result item carries the 30-bit crystal hit mask, its population count, the
// clock flag and five saturating 48-bit running totals. One item is taken per
// clock while the output is not stalled; each result passes through the
// two-stage channel lanes (increment stage, then accumulate stage). The output
// register holds a result under backpressure; one more item can still move
// into an empty increment stage. Write the clear-rule register only while idle.
module event_scaler_and_hit_tracker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: clear_rule_mask
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [esht_pkg::CfgW-1:0]     i_cfg_data,
    // Event items in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // coin_reg_low, coin_reg_high, ch0_count_low, ch0_count_high, ...,
    // ch4_count_low, ch4_count_high (16 bits each)
    input  logic [esht_pkg::InDataW-1:0]  s_axis_tdata,
    // Result items out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit_mask (30), hit_count (5), clock_flag (1), total_ch0..total_ch4
    // (48 each), zero pad (4)
    output logic [esht_pkg::OutDataW-1:0] m_axis_tdata
);
    import esht_pkg::*;

    logic [CfgW-1:0]    r_cfg;
    logic               r_s1_valid;
    logic [MaskW-1:0]   r_s1_mask;
    logic               r_s1_clk;
    logic               r_out_valid;
    logic [MaskW-1:0]   r_out_mask;
    logic [CountW-1:0]  r_out_count;
    logic               r_out_clk;
    logic [CountW-1:0]  n_out_count;

    logic               w_adv2;
    logic               w_adv1;
    t_lane_ctl          w_ctl;
    t_total             w_total [NumCh];
    t_half              w_coin_low;
    t_half              w_coin_high;

    // Stage enables: output slot free, then increment stage free
    assign w_adv2        = !r_out_valid || m_axis_tready;
    assign w_adv1        = !r_s1_valid || w_adv2;
    assign s_axis_tready = w_adv1;
    assign w_ctl.load    = s_axis_tvalid && w_adv1;
    assign w_ctl.acc     = r_s1_valid && w_adv2;

    assign w_coin_low  = s_axis_tdata[HalfW-1:0];
    assign w_coin_high = s_axis_tdata[2*HalfW-1:HalfW];

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ClearRuleReset;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Channel lanes
    for (genvar c = 0; c < NumCh; c++) begin : g_lane
        esht_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_low   (s_axis_tdata[(2*c+2)*HalfW +: HalfW]),
            .i_high  (s_axis_tdata[(2*c+3)*HalfW +: HalfW]),
            .i_alt   (r_cfg[c]),
            .o_total (w_total[c])
        );
    end

    // Count the hit crystals
    always_comb begin
        n_out_count = '0;
        for (int i = 0; i < MaskW; i++) begin
            n_out_count = n_out_count + CountW'(r_s1_mask[i]);
        end
    end

    // Valid flags of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_adv2) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Hit payload through the two stages
    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_s1_mask <= {w_coin_high[HighHitW-1:0], w_coin_low};
            r_s1_clk  <= w_coin_high[ClockBit];
        end
        if (w_ctl.acc) begin
            r_out_mask  <= r_s1_mask;
            r_out_count <= n_out_count;
            r_out_clk   <= r_s1_clk;
        end
    end

    // Merge hit fields and lane totals into the result
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[MaskW-1:0]             = r_out_mask;
        m_axis_tdata[MaskW +: CountW]       = r_out_count;
        m_axis_tdata[MaskW + CountW]        = r_out_clk;
        for (int c = 0; c < NumCh; c++) begin
            m_axis_tdata[OutTotOfs + c*TotalW +: TotalW] = w_total[c];
        end
    end
    assign m_axis_tvalid = r_out_valid;

    // Checks
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count == CountW'($countones(r_out_mask))))
        else $error("hit count does not match hit mask");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_s1_valid)
        else $error("accepted item lost before increment stage");

    a_s1_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv2) |=> r_out_valid)
        else $error("increment stage item not delivered to output");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> s_axis_tready)
        else $error("input stalled with empty increment stage");

endmodule

// ----- rtl/esht_lane.sv -----
module esht_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  esht_pkg::t_lane_ctl i_ctl,
    input  esht_pkg::t_half     i_low,
    input  esht_pkg::t_half     i_high,
    input  logic                i_alt,
    output esht_pkg::t_total    o_total   // two's complement running total
);
    import esht_pkg::*;

    logic [HalfW-1:0]  r_prev_low;
    logic [HalfW-1:0]  r_prev_high;
    logic [IncW-1:0]   r_inc;
    logic [TotalW-1:0] r_total;
    logic [TotalW-1:0] n_total;

    logic [HalfW:0]    w_dl;
    logic              w_clear;
    logic [HalfW-1:0]  w_dh;
    logic [IncW-1:0]   w_inc;
    logic [TotalW:0]   w_sum;

    // Form the increment against the stored scaler words
    always_comb begin
        w_dl    = {1'b0, i_low} - {1'b0, r_prev_low};
        w_clear = r_prev_high > i_high;
        w_dh    = w_clear ? {{(HalfW-1){1'b0}}, i_alt} : (i_high - r_prev_high);
        w_inc   = {{(IncW-HalfW-1){w_dl[HalfW]}}, w_dl}
                + {{(IncW-2*HalfW){1'b0}}, w_dh, {HalfW{1'b0}}};
    end

    // Add and clamp to the signed total range
    always_comb begin
        w_sum = {r_total[TotalW-1], r_total}
              + {{(TotalW+1-IncW){r_inc[IncW-1]}}, r_inc};
        if (w_sum[TotalW] != w_sum[TotalW-1]) begin
            n_total = w_sum[TotalW] ? TotalMin : TotalMax;
        end else begin
            n_total = w_sum[TotalW-1:0];
        end
    end

    // Hold previous scaler words and the running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_low  <= '0;
            r_prev_high <= '0;
            r_total     <= '0;
        end else begin
            if (i_ctl.load) begin
                r_prev_low  <= i_low;
                r_prev_high <= i_high;
            end
            if (i_ctl.acc) begin
                r_total <= n_total;
            end
        end
    end

    // Increment register, payload only
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_inc <= w_inc;
        end
    end

    assign o_total = r_total;

endmodule
